FILE: rtl/core/press_duration_gesture_counter_macros.svh
// Assertion helpers for the RTL.
`ifndef PRESS_DURATION_GESTURE_COUNTER_MACROS_SVH
`define PRESS_DURATION_GESTURE_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PDGC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pdgc assertion failed");

// Next-cycle implication, disabled while reset is low.
`define PDGC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pdgc assertion failed");

`endif

FILE: rtl/core/pdgc_pkg.sv
package pdgc_pkg;

    localparam int CFG_W   = 16;  // tick threshold register width
    localparam int CNT3_W  = 3;   // press counter / needed count width
    localparam int ADDR_W  = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CFG_W-1:0]  SHORT_TICKS_RST   = 16'd10;
    localparam logic [CFG_W-1:0]  LONG_TICKS_RST    = 16'd50;
    localparam logic [CFG_W-1:0]  TIMEOUT_TICKS_RST = 16'd150;
    localparam logic [CNT3_W-1:0] LONG_NEEDED_RST   = 3'd2;
    localparam logic [CNT3_W-1:0] VALID_NEEDED_RST  = 3'd3;
    localparam logic [CNT3_W-1:0] CNT3_MAX          = 3'd7;

    typedef enum logic [ADDR_W-1:0] {
        CFG_SHORT_TICKS   = 3'd0,
        CFG_LONG_TICKS    = 3'd1,
        CFG_TIMEOUT_TICKS = 3'd2,
        CFG_LONG_NEEDED   = 3'd3,
        CFG_VALID_NEEDED  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PC_NONE  = 2'd0,
        PC_SHORT = 2'd1,
        PC_VALID = 2'd2,
        PC_LONG  = 2'd3
    } t_press_class;

    typedef enum logic [1:0] {
        TRIG_NONE   = 2'd0,
        TRIG_CONFIG = 2'd1,
        TRIG_ENROLL = 2'd2
    } t_trigger;

    typedef struct packed {
        logic [CFG_W-1:0]  short_ticks;
        logic [CFG_W-1:0]  long_ticks;
        logic [CFG_W-1:0]  timeout_ticks;
        logic [CNT3_W-1:0] long_needed;
        logic [CNT3_W-1:0] valid_needed;
    } t_cfg;

    typedef struct packed {
        logic              pressing;
        logic [CNT3_W-1:0] long_count;
        logic [CNT3_W-1:0] valid_count;
        logic              timeout_cleared;
        t_trigger          trigger;
        t_press_class      press_class;
    } t_result;

    function automatic logic [CNT3_W-1:0] sat_inc3(input logic [CNT3_W-1:0] v);
        sat_inc3 = (v == CNT3_MAX) ? v : v + 3'd1;
    endfunction

endpackage

FILE: rtl/core/pdgc_core.sv
// Gesture state and per-sample update. o_result is combinational from
// the current state and the sample; state commits on i_step.
module pdgc_core #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pdgc_pkg::t_cfg   i_cfg,
    input  logic             i_step,
    input  logic             i_touched,
    output pdgc_pkg::t_result o_result
);
    import pdgc_pkg::*;

`include "press_duration_gesture_counter_macros.svh"

    localparam int CMP_W = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

    logic                     r_active;
    logic [COUNTER_WIDTH-1:0] r_press_len;
    logic [COUNTER_WIDTH-1:0] r_idle_len;
    logic [CNT3_W-1:0]        r_valid;
    logic [CNT3_W-1:0]        r_long;

    logic                     n_active;
    logic [COUNTER_WIDTH-1:0] n_press_len;
    logic [COUNTER_WIDTH-1:0] n_idle_len;
    logic [CNT3_W-1:0]        n_valid;
    logic [CNT3_W-1:0]        n_long;

    logic [COUNTER_WIDTH-1:0] w_press_inc;
    logic [COUNTER_WIDTH-1:0] w_idle_inc;
    logic                     w_is_long;
    logic                     w_is_valid;
    logic                     w_timeout;

    assign w_press_inc = (r_press_len == CNT_MAX) ? r_press_len : r_press_len + 1'b1;
    assign w_idle_inc  = (r_idle_len == CNT_MAX) ? r_idle_len : r_idle_len + 1'b1;

    // release tick sees the incremented press length
    assign w_is_long  = CMP_W'(w_press_inc) >= CMP_W'(i_cfg.long_ticks);
    assign w_is_valid = CMP_W'(w_press_inc) >= CMP_W'(i_cfg.short_ticks);

    always_comb begin
        n_active    = r_active;
        n_press_len = r_active ? w_press_inc : r_press_len;
        n_idle_len  = r_active ? r_idle_len : w_idle_inc;
        n_valid     = r_valid;
        n_long      = r_long;
        o_result    = '0;
        o_result.press_class = PC_NONE;
        o_result.trigger     = TRIG_NONE;

        if (i_touched && !r_active) begin
            n_active    = 1'b1;
            n_press_len = '0;
        end else if (!i_touched && r_active) begin
            n_active = 1'b0;
            if (w_is_long) begin
                o_result.press_class = PC_LONG;
                n_valid = sat_inc3(r_valid);
                n_long  = sat_inc3(r_long);
                if (n_long >= i_cfg.long_needed) begin
                    o_result.trigger = TRIG_CONFIG;
                end else if (n_valid >= i_cfg.valid_needed) begin
                    o_result.trigger = TRIG_ENROLL;
                end
            end else if (w_is_valid) begin
                o_result.press_class = PC_VALID;
                n_valid = sat_inc3(r_valid);
                if (n_valid >= i_cfg.valid_needed) begin
                    o_result.trigger = TRIG_ENROLL;
                end
            end else begin
                o_result.press_class = PC_SHORT;
            end
            if (o_result.trigger != TRIG_NONE) begin
                n_valid = '0;
                n_long  = '0;
            end
            n_idle_len = '0;
        end

        // idle timeout, after release handling
        w_timeout = !n_active && (n_valid != '0) &&
                    (CMP_W'(n_idle_len) > CMP_W'(i_cfg.timeout_ticks));
        if (w_timeout) begin
            n_valid = '0;
            n_long  = '0;
        end

        o_result.timeout_cleared = w_timeout;
        o_result.valid_count     = n_valid;
        o_result.long_count      = n_long;
        o_result.pressing        = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_press_len <= '0;
            r_idle_len  <= '0;
            r_valid     <= '0;
            r_long      <= '0;
        end else if (i_step) begin
            r_active    <= n_active;
            r_press_len <= n_press_len;
            r_idle_len  <= n_idle_len;
            r_valid     <= n_valid;
            r_long      <= n_long;
        end
    end

    `PDGC_ASSERT_IMP(a_long_le_valid, i_clk, i_rst_n, 1'b1, r_long <= r_valid)
    `PDGC_ASSERT_IMP(a_trigger_clears, i_clk, i_rst_n, i_step && (o_result.trigger != TRIG_NONE), (o_result.valid_count == '0) && (o_result.long_count == '0))
    `PDGC_ASSERT_IMP(a_timeout_when_idle, i_clk, i_rst_n, i_step && o_result.timeout_cleared, (o_result.press_class == PC_NONE) && !o_result.pressing)
    `PDGC_ASSERT_NXT(a_press_start, i_clk, i_rst_n, i_step && i_touched && !r_active, r_active && (r_press_len == '0))

endmodule

FILE: rtl/core/press_duration_gesture_counter.sv
// Each result is registered and appears on the master side the cycle after its sample transaction.
// Throughput: one sample per clock; the output register frees s_axis_tready whenever
//   the held result is taken in the same cycle or none is held.
// Reset (i_rst_n low, synchronous): press/idle tick counters and press counts clear,
//   no press in progress, thresholds return to 10 / 50 / 150 ticks and 2 / 3 presses.
module press_duration_gesture_counter #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [pdgc_pkg::ADDR_W-1:0]         i_cfg_addr,
    input  logic [pdgc_pkg::CFG_W-1:0]          i_cfg_data,
    // sample stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pdgc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [0] touched, rest zero
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] press_class, [3:2] trigger, [4] timeout_cleared, [7:5] valid_count,
    // [10:8] long_count, [11] pressing, [15:12] zero
    output logic [pdgc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import pdgc_pkg::*;

    // Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
    t_cfg    r_cfg;
    t_result w_result;
    logic    w_step;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_ticks   <= SHORT_TICKS_RST;
            r_cfg.long_ticks    <= LONG_TICKS_RST;
            r_cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
            r_cfg.long_needed   <= LONG_NEEDED_RST;
            r_cfg.valid_needed  <= VALID_NEEDED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SHORT_TICKS:   r_cfg.short_ticks   <= i_cfg_data;
                CFG_LONG_TICKS:    r_cfg.long_ticks    <= i_cfg_data;
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data;
                CFG_LONG_NEEDED:   r_cfg.long_needed   <= i_cfg_data[CNT3_W-1:0];
                CFG_VALID_NEEDED:  r_cfg.valid_needed  <= i_cfg_data[CNT3_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // A sample is taken whenever the output register is empty or draining.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_step        = s_axis_tvalid && s_axis_tready;

    pdgc_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_step    (w_step),
        .i_touched (s_axis_tdata[0]),
        .o_result  (w_result)
    );

    // Result register: loads on every accepted sample, holds while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= {4'b0000,
                           w_result.pressing,
                           w_result.long_count,
                           w_result.valid_count,
                           w_result.timeout_cleared,
                           w_result.trigger,
                           w_result.press_class};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
